>>> src/lifo_pkg.sv
// Shared constants for the LIFO word store: depth default, operation codes and status codes.
`default_nettype none
package lifo_pkg;

  localparam int LIFO_DEPTH = 16;
  localparam int WORD_W     = 32;

  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_UPDATE = 3'd2;
  localparam logic [2:0] FN_CLEAR  = 3'd3;
  localparam logic [2:0] FN_DUMP   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage
`default_nettype wire

>>> src/lifo_ram.sv
// Single-port-write, single-port-read word memory with a registered read.
`default_nettype none
module lifo_ram #(
  parameter int DEPTH = lifo_pkg::LIFO_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [AW-1:0]                        wr_addr,
  input  wire  logic signed [lifo_pkg::WORD_W-1:0] wr_data,
  input  wire                                  rd_en,
  input  wire  [AW-1:0]                        rd_addr,
  output logic signed [lifo_pkg::WORD_W-1:0]   rd_data
);

  logic signed [lifo_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/lifo_store_with_match_update.sv
// Top level of the bounded LIFO word store with push, pop, update, clear and dump.
//
//  Channel  Direction  Handshake              Words
//  in_      sink       in_valid / in_ready    in_func, in_value, in_match_key
//  out_     source     out_valid / out_ready  out_status, out_value, out_last
//
// One item is processed at a time; the words live in a memory with a registered read.
// A dump emits every stored word from the top down and marks the bottom word as last.
// Update reads the entries one at a time from the top down until one matches the key.
// After reset the store is empty and the block is ready.
// A stalled output holds its word; work that must emit waits until the output slot frees.
`default_nettype none
module lifo_store_with_match_update #(
  parameter int DEPTH = lifo_pkg::LIFO_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [2:0]                          in_func,
  input  wire  logic signed [lifo_pkg::WORD_W-1:0] in_value,
  input  wire  logic signed [lifo_pkg::WORD_W-1:0] in_match_key,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [1:0]                          out_status,
  output logic signed [lifo_pkg::WORD_W-1:0]  out_value,
  output logic                                out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_CHECK} state_t;

  state_t                               state_r, state_nxt;
  logic [CW-1:0]                        cnt_r, cnt_nxt;
  logic [AW-1:0]                        idx_r, idx_nxt;
  logic [2:0]                           func_r;
  logic signed [lifo_pkg::WORD_W-1:0]   value_r, key_r;

  logic                                 out_valid_r;
  logic [1:0]                           out_status_r;
  logic signed [lifo_pkg::WORD_W-1:0]   out_value_r;
  logic                                 out_last_r;

  logic                                 can_load, emit;
  logic [1:0]                           ld_status;
  logic signed [lifo_pkg::WORD_W-1:0]   ld_value;
  logic                                 ld_last;
  logic                                 wr_en, rd_en;
  logic [AW-1:0]                        wr_addr;
  logic signed [lifo_pkg::WORD_W-1:0]   rd_data;
  logic                                 empty, full;
  logic [AW-1:0]                        top_idx;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  assign can_load = !out_valid_r || out_ready;
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r >= FULL_CNT);
  assign top_idx  = AW'(cnt_r - CW'(1));
  assign rd_en    = (state_r == S_READ);

  lifo_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    ld_status = lifo_pkg::ST_OK;
    ld_value  = '0;
    ld_last   = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          state_nxt = S_IDLE;
          case (func_r)
            lifo_pkg::FN_PUSH: begin
              emit = 1'b1;
              if (full) begin
                ld_status = lifo_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_r);
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            lifo_pkg::FN_POP, lifo_pkg::FN_DUMP: begin
              if (empty) begin
                emit      = 1'b1;
                ld_status = lifo_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = top_idx;
                state_nxt = S_READ;
              end
            end
            lifo_pkg::FN_UPDATE: begin
              if (empty) begin
                emit      = 1'b1;
                ld_status = lifo_pkg::ST_MISSING;
              end else begin
                idx_nxt   = top_idx;
                state_nxt = S_READ;
              end
            end
            lifo_pkg::FN_CLEAR: begin
              emit      = 1'b1;
              ld_status = empty ? lifo_pkg::ST_EMPTY : lifo_pkg::ST_OK;
              cnt_nxt   = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (func_r)
          lifo_pkg::FN_POP: begin
            if (can_load) begin
              emit      = 1'b1;
              ld_value  = rd_data;
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_IDLE;
            end
          end
          lifo_pkg::FN_DUMP: begin
            if (can_load) begin
              emit     = 1'b1;
              ld_value = rd_data;
              ld_last  = (idx_r == '0);
              if (idx_r == '0) begin
                state_nxt = S_IDLE;
              end else begin
                idx_nxt   = idx_r - AW'(1);
                state_nxt = S_READ;
              end
            end
          end
          lifo_pkg::FN_UPDATE: begin
            if (rd_data == key_r) begin
              if (can_load) begin
                emit      = 1'b1;
                wr_en     = 1'b1;
                state_nxt = S_IDLE;
              end
            end else if (idx_r == '0) begin
              if (can_load) begin
                emit      = 1'b1;
                ld_status = lifo_pkg::ST_MISSING;
                state_nxt = S_IDLE;
              end
            end else begin
              idx_nxt   = idx_r - AW'(1);
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r  <= in_func;
      value_r <= in_value;
      key_r   <= in_match_key;
    end
    if (emit) begin
      out_status_r <= ld_status;
      out_value_r  <= ld_value;
      out_last_r   <= ld_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("fill count exceeds the store depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == lifo_pkg::ST_FULL |-> cnt_r == FULL_CNT)
    else $error("full status reported while the store has room");

  a_inner_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_status_r == lifo_pkg::ST_OK)
    else $error("non-final word carries an error status");

  a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r && out_status_r == lifo_pkg::ST_OK)
    else $error("memory written without a successful result");

endmodule
`default_nettype wire
